/* sv/mip_box_downsample_unit_defines.svh */
// ----------------------------------------------------------------------------
// mip_box_downsample_unit_defines
// Assertion macros used by the box downsample RTL.
// ----------------------------------------------------------------------------
`ifndef MIP_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH
`define MIP_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MBD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mbd_pkg.sv */
// ----------------------------------------------------------------------------
// mbd_pkg
// Types and constants of the box filter mip level downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  // limits of the source image and block size
  localparam int MaxWidth      = 2048;
  localparam int HeightLimit   = 2048;
  localparam int MaxLevelShift = 11;

  // field and counter widths
  localparam int ChanW  = 8;
  localparam int DimW   = 12;
  localparam int ShiftW = 4;
  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(HeightLimit);
  localparam int SumW   = 2 * MaxLevelShift + ChanW;

  // register port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [ChanW-1:0] OpaqueAlpha = 8'd255;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegShift  = 2'd2,
    RegOpaque = 2'd3
  } reg_idx_e;

  // effective configuration after bounding
  typedef struct packed {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [ShiftW-1:0] shift;
    logic              opaque;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic             level_done;
  } out_pix_t;

  // one accumulator entry: partial block sums of all channels
  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
    logic [SumW-1:0] alpha;
  } sum_t;

  // where the current source pixel falls in the block grid
  typedef struct packed {
    logic [ColW-1:0] addr;
    logic            in_block;
    logic            first;
    logic            last;
    logic            done;
  } pos_t;

endpackage

/* sv/mip_box_downsample_unit.sv */
// ----------------------------------------------------------------------------
// mip_box_downsample_unit
// One mip level of an RGBA8 raster stream by 2^s x 2^s box averaging.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid_i/in_stall_o  in_pix_i  (mbd_pkg::in_pix_t)
//  out       source     out_valid_o/out_stall_i out_pix_o (mbd_pkg::out_pix_t)
//  cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// One item per clock while no held result stalls the update stage; each item
// reads the column accumulator RAM on acceptance and, if in a block, writes it
// back as the update stage fires, which also registers a block's result.
// A same-column write on the read edge is forwarded from a bypass register.
// Reset clears the raster counters and control; the RAM is not cleared.
// A held result stalls the update stage only when that stage carries one.
// ----------------------------------------------------------------------------
`include "mip_box_downsample_unit_defines.svh"

module mip_box_downsample_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mbd_pkg::AddrW-1:0] paddr,
  input  logic [mbd_pkg::DataW-1:0] pwdata,
  output logic [mbd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mbd_pkg::in_pix_t          in_pix_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mbd_pkg::out_pix_t         out_pix_o
);
  import mbd_pkg::*;

  cfg_t     cfg;
  pos_t     pos;
  logic     in_acc;

  logic     s1_valid_q;
  in_pix_t  s1_pix_q;
  pos_t     s1_pos_q;
  logic     s1_hit_q;
  logic     s1_fire;
  logic     wr_en;

  sum_t     rd_data;
  sum_t     byp_q;
  sum_t     base;
  sum_t     sum_new;
  logic [4:0] sum_sh;

  logic     out_valid_q;
  out_pix_t out_pix_q;

  // configuration registers
  mbd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // raster position of the next item
  mbd_pos_track u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (in_acc),
    .pos_o     (pos)
  );

  // column accumulators
  mbd_sum_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_pos_q.addr),
    .wdata_i (sum_new),
    .re_i    (in_acc),
    .raddr_i (pos.addr),
    .rdata_o (rd_data)
  );

  // handshake of the update stage
  assign s1_fire    = s1_valid_q && (!s1_pos_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = s1_fire && s1_pos_q.in_block;

  // update stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= in_pix_i;
      s1_pos_q <= pos;
      s1_hit_q <= wr_en && (s1_pos_q.addr == pos.addr);
    end
  end

  // bypass of the write that lands on the read edge
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_q <= sum_new;
    end
  end

  // accumulate, restarting at the top-left pixel of a block
  always_comb begin
    if (s1_pos_q.first) begin
      base = '0;
    end else if (s1_hit_q) begin
      base = byp_q;
    end else begin
      base = rd_data;
    end
    sum_new.red   = base.red   + SumW'(s1_pix_q.in_red);
    sum_new.green = base.green + SumW'(s1_pix_q.in_green);
    sum_new.blue  = base.blue  + SumW'(s1_pix_q.in_blue);
    sum_new.alpha = base.alpha + SumW'(s1_pix_q.in_alpha);
  end

  assign sum_sh = {cfg.shift, 1'b0};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_pos_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_pos_q.last) begin
      out_pix_q.out_red    <= ChanW'(sum_new.red >> sum_sh);
      out_pix_q.out_green  <= ChanW'(sum_new.green >> sum_sh);
      out_pix_q.out_blue   <= ChanW'(sum_new.blue >> sum_sh);
      out_pix_q.out_alpha  <= cfg.opaque ? OpaqueAlpha : ChanW'(sum_new.alpha >> sum_sh);
      out_pix_q.level_done <= s1_pos_q.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  // checks
  `MBD_ASSERT_NEXT(a_acc_enters_s1, in_acc, s1_valid_q, "accepted item missing in update stage")
  `MBD_ASSERT_NOW(a_last_in_block, s1_valid_q && s1_pos_q.last, s1_pos_q.in_block, "result outside a block")
  `MBD_ASSERT_NEXT(a_result_loaded, s1_fire && s1_pos_q.last, out_valid_o, "completed block lost")

endmodule

/* sv/mbd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mbd_cfg_regs
// Register file behind the APB-style port, with bounded effective values.
// ----------------------------------------------------------------------------
module mbd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mbd_pkg::AddrW-1:0] paddr,
  input  logic [mbd_pkg::DataW-1:0] pwdata,
  output logic [mbd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output mbd_pkg::cfg_t             cfg_o
);
  import mbd_pkg::*;

  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [ShiftW-1:0] shift_q;
  logic              opaque_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(256);
      height_q <= DimW'(256);
      shift_q  <= ShiftW'(1);
      opaque_q <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        RegWidth:  width_q  <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        RegShift:  shift_q  <= pwdata[ShiftW-1:0];
        RegOpaque: opaque_q <= pwdata[0];
        default:   ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      RegWidth:  prdata = DataW'(width_q);
      RegHeight: prdata = DataW'(height_q);
      RegShift:  prdata = DataW'(shift_q);
      RegOpaque: prdata = DataW'(opaque_q);
      default:   prdata = '0;
    endcase
  end

  // zero width or height acts as one, oversized values act as the limit
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      cfg_o.width = DimW'(MaxWidth);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = DimW'(1);
    end else if (height_q > DimW'(HeightLimit)) begin
      cfg_o.height = DimW'(HeightLimit);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.shift  = (shift_q > ShiftW'(MaxLevelShift)) ? ShiftW'(MaxLevelShift) : shift_q;
    cfg_o.opaque = opaque_q;
  end

endmodule

/* sv/mbd_pos_track.sv */
// ----------------------------------------------------------------------------
// mbd_pos_track
// Raster position counters and block grid decode of the incoming pixel.
// ----------------------------------------------------------------------------
module mbd_pos_track (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mbd_pkg::cfg_t cfg_i,
  input  logic          advance_i,
  output mbd_pkg::pos_t pos_o
);
  import mbd_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_mask;
  logic [RowW-1:0] row_mask;
  logic [ColW-1:0] bx;
  logic [RowW-1:0] by;
  logic [DimW-1:0] ow;
  logic [DimW-1:0] oh;
  logic [DimW-1:0] col_nxt;
  logic [DimW-1:0] row_nxt;
  logic            in_block;

  // block grid of the current pixel
  assign col_mask = ~({ColW{1'b1}} << cfg_i.shift);
  assign row_mask = ~({RowW{1'b1}} << cfg_i.shift);
  assign bx       = col_q >> cfg_i.shift;
  assign by       = row_q >> cfg_i.shift;
  assign ow       = cfg_i.width >> cfg_i.shift;
  assign oh       = cfg_i.height >> cfg_i.shift;

  assign in_block = (DimW'(col_q) < cfg_i.width) && (DimW'(row_q) < cfg_i.height)
                 && (DimW'(bx) < ow) && (DimW'(by) < oh);

  assign pos_o.addr     = bx;
  assign pos_o.in_block = in_block;
  assign pos_o.first    = ((col_q & col_mask) == '0) && ((row_q & row_mask) == '0);
  assign pos_o.last     = in_block && ((col_q & col_mask) == col_mask)
                       && ((row_q & row_mask) == row_mask);
  assign pos_o.done     = (DimW'(bx) == ow - DimW'(1)) && (DimW'(by) == oh - DimW'(1));

  // raster advance with wrap at the image bounds
  assign col_nxt = DimW'(col_q) + DimW'(1);
  assign row_nxt = DimW'(row_q) + DimW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_nxt >= cfg_i.width) begin
        col_d = '0;
        row_d = (row_nxt >= cfg_i.height) ? '0 : row_nxt[RowW-1:0];
      end else begin
        col_d = col_nxt[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* sv/mbd_sum_ram.sv */
// ----------------------------------------------------------------------------
// mbd_sum_ram
// Row of partial block sums, one entry per output column, registered read.
// ----------------------------------------------------------------------------
module mbd_sum_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [mbd_pkg::ColW-1:0] waddr_i,
  input  mbd_pkg::sum_t            wdata_i,
  input  logic                     re_i,
  input  logic [mbd_pkg::ColW-1:0] raddr_i,
  output mbd_pkg::sum_t            rdata_o
);
  import mbd_pkg::*;

  sum_t mem [MaxWidth];
  sum_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
